### hdl/rgb_to_i420_converter_defines.svh
// assertion macros shared by the converter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef RGB_TO_I420_CONVERTER_DEFINES_SVH
`define RGB_TO_I420_CONVERTER_DEFINES_SVH

// same-cycle implication on clk, off during rst
`define CHK_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication on clk, off during rst
`define CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### hdl/rgb2i420_pkg.sv
// shared types, codes and constants for the rgb to i420 converter
// no dependencies; imported by the converter top level
package rgb2i420_pkg;

  // field and state widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned IDX_W   = 22;
  localparam int unsigned CCNT_W  = 20;
  localparam int unsigned TERM_W  = 11;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned REG_W   = 1;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [REG_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // plane codes
  localparam logic [1:0] PLANE_Y  = 2'd0;
  localparam logic [1:0] PLANE_CB = 2'd1;
  localparam logic [1:0] PLANE_CR = 2'd2;

  // luma weights, scaled by 1024
  localparam logic [17:0] Y_WB = 18'd117;
  localparam logic [17:0] Y_WG = 18'd601;
  localparam logic [17:0] Y_WR = 18'd306;

  // chroma scale factors and offset, scaled by 1024
  localparam logic signed [20:0] CB_MUL     = 21'sd578;
  localparam logic signed [20:0] CR_MUL     = 21'sd730;
  localparam logic signed [20:0] CHROMA_OFS = 21'sd131072;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUMA,
    ST_EMIT_Y,
    ST_EMIT_CB,
    ST_EMIT_CR
  } state_t;

  // clamp a quarter sum to a byte
  function automatic logic [PIX_W-1:0] sat8(input logic signed [9:0] q);
    logic [PIX_W-1:0] v;
    if (q < 10'sd0) begin
      v = '0;
    end else if (q > 10'sd255) begin
      v = 8'd255;
    end else begin
      v = q[PIX_W-1:0];
    end
    return v;
  endfunction

endpackage

### hdl/rgb2i420_ram.sv
// generic simple dual-port ram with registered read
// no dependencies; holds the chroma line of the converter
module rgb2i420_ram #(
  parameter int unsigned WIDTH  = 22,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/rgb_to_i420_converter.sv
// luma path: pixel registered on accept, luma registered in the luma step, then the output register
// a new pixel is taken only as the last sample of the previous one goes out (luma, cb, cr
// go out one per cycle, unless the output is stalled, through a single output register)
// the chroma line store has one write and one read port, used in different states
// reset: counters, sequencer and sizes (640x480) cleared, input and config held off;
// line store not cleared; depends on rgb2i420_pkg, rgb2i420_ram and the assertion macros
`include "rgb_to_i420_converter_defines.svh"

module rgb_to_i420_converter
  import rgb2i420_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic               clk,
  input  logic               rst,
  // pixel input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   blue,
  input  logic [PIX_W-1:0]   green,
  input  logic [PIX_W-1:0]   red,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         plane,
  output logic [IDX_W-1:0]   plane_index,
  output logic [PIX_W-1:0]   sample_value,
  output logic               last_of_run,
  output logic               frame_end,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int unsigned W_W        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W        = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned LP_W       = COUNT_W + W_W;

  // control state
  state_t               state, state_next;
  logic [CFG_W-1:0]     frame_width, frame_height;
  logic [COUNT_W-1:0]   column_count, row_count;
  logic [CCNT_W-1:0]    chroma_count;
  logic [2*TERM_W-1:0]  pair_partial;

  // per-pixel payload
  logic [PIX_W-1:0]     blue_q, green_q, red_q;
  logic [PIX_W-1:0]     y_q;
  logic [IDX_W-1:0]     lidx_q;
  logic                 rd_ok;
  logic signed [TERM_W-1:0] sb_q, sr_q;
  logic                 fend_q;
  logic [CCNT_W-1:0]    cidx_q;

  // combinational
  logic [CFG_W-1:0]     fw_even, fh_even;
  logic [31:0]          w_full, h_full;
  logic [W_W-1:0]       w_eff;
  logic [H_W-1:0]       h_eff;
  logic                 row_end, row_last, emit_c;
  logic [COUNT_W-2:0]   li;
  logic                 li_ok;
  logic [17:0]          y_sum;
  logic [LP_W-1:0]      lidx_full;
  logic signed [9:0]    db, dr;
  logic signed [20:0]   cb_t, cr_t;
  logic signed [TERM_W-1:0] cb_term, cr_term, sb, sr;
  logic signed [TERM_W-1:0] pair_cb, pair_cr, e_cb, e_cr;
  logic signed [11:0]   tb, tr;
  logic [PIX_W-1:0]     vb, vr;
  logic                 out_free, take, accept, push;
  logic [1:0]           push_plane;
  logic [IDX_W-1:0]     push_index;
  logic [PIX_W-1:0]     push_value;
  logic                 push_last, push_fend;
  logic                 rd_en, wr_en;
  logic [2*TERM_W-1:0]  rd_data;

  assign cfg_ready = !rst;

  // effective frame size: even, at least 2, at most the maximum
  always_comb begin
    fw_even = {frame_width[CFG_W-1:1], 1'b0};
    fh_even = {frame_height[CFG_W-1:1], 1'b0};
    if (fw_even < 12'd2) begin
      w_full = 32'd2;
    end else if (32'(fw_even) > MAX_WIDTH) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(fw_even);
    end
    if (fh_even < 12'd2) begin
      h_full = 32'd2;
    end else if (32'(fh_even) > MAX_HEIGHT) begin
      h_full = 32'(MAX_HEIGHT);
    end else begin
      h_full = 32'(fh_even);
    end
    w_eff = w_full[W_W-1:0];
    h_eff = h_full[H_W-1:0];
  end

  // position decode
  assign row_end  = (32'(column_count) + 32'd1) >= 32'(w_eff);
  assign row_last = (32'(row_count) + 32'd1) >= 32'(h_eff);
  assign emit_c   = row_count[0] & column_count[0];
  assign li       = column_count[COUNT_W-1:1];
  assign li_ok    = 32'(li) < LINE_DEPTH;

  // luma sum and luma plane index
  assign y_sum = 18'(blue_q) * Y_WB + 18'(green_q) * Y_WG + 18'(red_q) * Y_WR;
  assign lidx_full = LP_W'(row_count) * LP_W'(w_eff) + LP_W'(column_count);

  // per-pixel chroma terms, floor division by 1024
  always_comb begin
    db      = $signed({2'b00, blue_q}) - $signed({2'b00, y_q});
    dr      = $signed({2'b00, red_q}) - $signed({2'b00, y_q});
    cb_t    = 21'(db) * CB_MUL + CHROMA_OFS;
    cr_t    = 21'(dr) * CR_MUL + CHROMA_OFS;
    cb_term = cb_t[20:10];
    cr_term = cr_t[20:10];
    pair_cb = pair_partial[TERM_W-1:0];
    pair_cr = pair_partial[2*TERM_W-1:TERM_W];
    sb      = pair_cb + cb_term;
    sr      = pair_cr + cr_term;
  end

  // block sums from line entry plus odd-row pair, quarter and clamp
  always_comb begin
    e_cb = rd_ok ? rd_data[TERM_W-1:0] : '0;
    e_cr = rd_ok ? rd_data[2*TERM_W-1:TERM_W] : '0;
    tb   = 12'(e_cb) + 12'(sb_q);
    tr   = 12'(e_cr) + 12'(sr_q);
    vb   = sat8(tb[11:2]);
    vr   = sat8(tr[11:2]);
  end

  assign out_free = !out_valid || !out_stall;

  // sequencer outputs
  always_comb begin
    take       = 1'b0;
    push       = 1'b0;
    push_plane = PLANE_Y;
    push_index = lidx_q;
    push_value = y_q;
    push_last  = 1'b1;
    push_fend  = fend_q;
    unique case (state)
      ST_IDLE: begin
        take = 1'b1;
      end
      ST_LUMA: begin
        take = 1'b0;
      end
      ST_EMIT_Y: begin
        push      = out_free;
        push_last = !emit_c;
        push_fend = row_end && row_last;
        take      = out_free && !emit_c;
      end
      ST_EMIT_CB: begin
        push       = out_free;
        push_plane = PLANE_CB;
        push_index = IDX_W'(cidx_q);
        push_value = vb;
        push_last  = 1'b0;
      end
      ST_EMIT_CR: begin
        push       = out_free;
        push_plane = PLANE_CR;
        push_index = IDX_W'(cidx_q);
        push_value = vr;
        take       = out_free;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // no item is taken while in reset
  assign in_stall = rst || !take;
  assign accept   = in_valid && !in_stall;

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LUMA;
      end
      ST_LUMA: begin
        state_next = ST_EMIT_Y;
      end
      ST_EMIT_Y: begin
        if (out_free) begin
          if (emit_c) state_next = ST_EMIT_CB;
          else if (in_valid) state_next = ST_LUMA;
          else state_next = ST_IDLE;
        end
      end
      ST_EMIT_CB: begin
        if (out_free) state_next = ST_EMIT_CR;
      end
      ST_EMIT_CR: begin
        if (out_free) state_next = in_valid ? ST_LUMA : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // line store: read while luma is formed, written when the luma goes out
  assign rd_en = (state == ST_LUMA) && emit_c;
  assign wr_en = (state == ST_EMIT_Y) && out_free && column_count[0] && !row_count[0]
                 && li_ok;

  rgb2i420_ram #(
    .WIDTH  (2 * TERM_W),
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (LINE_AW)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (LINE_AW'(li)),
    .wr_data ({sr, sb}),
    .rd_en   (rd_en),
    .rd_addr (LINE_AW'(li)),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      column_count <= '0;
      row_count    <= '0;
      chroma_count <= '0;
      pair_partial <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default:          frame_width  <= frame_width;
        endcase
      end
      // output valid
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // pixel retires when its luma goes out
      if (state == ST_EMIT_Y && out_free) begin
        if (!column_count[0]) begin
          pair_partial <= {cr_term, cb_term};
        end
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_last ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
        if (row_end && row_last) begin
          chroma_count <= '0;
        end else if (emit_c) begin
          chroma_count <= chroma_count + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      blue_q  <= blue;
      green_q <= green;
      red_q   <= red;
    end
    if (state == ST_LUMA) begin
      y_q    <= y_sum[17:10];
      lidx_q <= IDX_W'(lidx_full);
      rd_ok  <= li_ok;
    end
    if (state == ST_EMIT_Y && out_free) begin
      sb_q   <= sb;
      sr_q   <= sr;
      fend_q <= row_end && row_last;
      cidx_q <= chroma_count;
    end
    if (push) begin
      plane        <= push_plane;
      plane_index  <= push_index;
      sample_value <= push_value;
      last_of_run  <= push_last;
      frame_end    <= push_fend;
    end
  end

  // checks
  `CHK_NEXT(a_accept_to_luma, accept, state == ST_LUMA, "pixel item not followed by luma step")
  `CHK_SAME(a_line_ports, wr_en, !rd_en, "line store read and write in one cycle")
  `CHK_NEXT(a_cb_then_cr, (state == ST_EMIT_CB) && out_free, state == ST_EMIT_CR,
            "cb item without cr")
  `CHK_SAME(a_cr_is_last, out_valid && (plane == PLANE_CR), last_of_run, "cr item not last of run")

endmodule

### bench/rgb_to_i420_converter_tb.sv
// self-checking bench for rgb_to_i420_converter: bursty pixel driver, stalling
// result monitor and a bit-exact predictor of luma, cb and cr samples
// depends on rgb2i420_pkg and the converter rtl
module rgb_to_i420_converter_tb;
  import rgb2i420_pkg::*;

  localparam int FRAME_MAX_W = 2048;
  localparam int FRAME_MAX_H = 2048;
  localparam int LINE_DEPTH  = FRAME_MAX_W / 2;
  localparam int RANDOM_PIXELS = 180;

  // bt.601 weights and chroma scaling, all scaled by 1024
  localparam int LUMA_WB   = 117;
  localparam int LUMA_WG   = 601;
  localparam int LUMA_WR   = 306;
  localparam int CB_SCALE  = 578;
  localparam int CR_SCALE  = 730;
  localparam int CHROMA_MID = 128 << 10;

  typedef struct {
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] r;
  } pixel_t;

  typedef struct {
    logic [1:0]       plane;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] sample;
    logic             last_run;
    logic             fend;
  } sample_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   blue = '0;
  logic [PIX_W-1:0]   green = '0;
  logic [PIX_W-1:0]   red = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         plane;
  logic [IDX_W-1:0]   plane_index;
  logic [PIX_W-1:0]   sample_value;
  logic               last_of_run;
  logic               frame_end;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [REG_W-1:0]   cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]   cfg_data = '0;

  rgb_to_i420_converter #(
    .MAX_WIDTH (FRAME_MAX_W),
    .MAX_HEIGHT(FRAME_MAX_H)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .plane       (plane),
    .plane_index (plane_index),
    .sample_value(sample_value),
    .last_of_run (last_of_run),
    .frame_end   (frame_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // pixels waiting to be sent and samples waiting to come back
  pixel_t  pixel_q[$];
  sample_t sample_q[$];
  int      error_count = 0;

  // predictor copy of the converter registers and state
  logic [CFG_W-1:0]         width_reg  = FRAME_WIDTH_RST;
  logic [CFG_W-1:0]         height_reg = FRAME_HEIGHT_RST;
  logic [10:0]              col_pos = '0;
  logic [10:0]              row_pos = '0;
  logic signed [TERM_W-1:0] pair_cb = '0;
  logic signed [TERM_W-1:0] pair_cr = '0;
  logic signed [TERM_W-1:0] line_cb [LINE_DEPTH];
  logic signed [TERM_W-1:0] line_cr [LINE_DEPTH];
  logic [CCNT_W-1:0]        chroma_idx = '0;

  // size as the converter uses it: even, at least 2, at most the maximum
  function automatic int effective_size(input logic [CFG_W-1:0] v, input int limit);
    int s;
    s = int'(v) & ~1;
    if (s < 2) s = 2;
    if (s > limit) s = limit;
    return s;
  endfunction

  // floor of a quarter of a 2x2 sum, clamped to a byte
  function automatic logic [PIX_W-1:0] clamp_quarter(input int sum);
    int q;
    q = sum >>> 2;
    if (q < 0) return '0;
    if (q > 255) return 8'd255;
    return q[PIX_W-1:0];
  endfunction

  // luma for every pixel; cb and cr after the lower-right pixel of a block
  task automatic convert_pixel(input logic [PIX_W-1:0] b8, g8, r8);
    int      w, h, b, g, r, y, cb, cr, sb, sr, tb, tr, li;
    bit      row_end, frame_done, chroma_due;
    sample_t s;
    w = effective_size(width_reg, FRAME_MAX_W);
    h = effective_size(height_reg, FRAME_MAX_H);
    b = int'(b8);
    g = int'(g8);
    r = int'(r8);
    y = (LUMA_WB * b + LUMA_WG * g + LUMA_WR * r) >> 10;
    cb = ((b - y) * CB_SCALE + CHROMA_MID) >>> 10;
    cr = ((r - y) * CR_SCALE + CHROMA_MID) >>> 10;
    row_end = (int'(col_pos) + 1 >= w);
    frame_done = row_end && (int'(row_pos) + 1 >= h);
    chroma_due = row_pos[0] && col_pos[0];
    li = int'(col_pos) >> 1;

    s.plane = PLANE_Y;
    s.idx = IDX_W'(int'(row_pos) * w + int'(col_pos));
    s.sample = y[PIX_W-1:0];
    s.last_run = !chroma_due;
    s.fend = frame_done;
    sample_q.push_back(s);

    // even column opens a pair, odd column closes it
    if (!col_pos[0]) begin
      pair_cb = cb[TERM_W-1:0];
      pair_cr = cr[TERM_W-1:0];
    end else begin
      sb = int'(pair_cb) + cb;
      sr = int'(pair_cr) + cr;
      if (!row_pos[0]) begin
        line_cb[li] = sb[TERM_W-1:0];
        line_cr[li] = sr[TERM_W-1:0];
      end else begin
        tb = int'(line_cb[li]) + sb;
        tr = int'(line_cr[li]) + sr;
        s.plane = PLANE_CB;
        s.idx = IDX_W'(chroma_idx);
        s.sample = clamp_quarter(tb);
        s.last_run = 1'b0;
        sample_q.push_back(s);
        s.plane = PLANE_CR;
        s.sample = clamp_quarter(tr);
        s.last_run = 1'b1;
        sample_q.push_back(s);
        chroma_idx = chroma_idx + 1'b1;
      end
    end

    // raster position of the next pixel
    if (row_end) begin
      col_pos = '0;
      if (frame_done) begin
        row_pos = '0;
        chroma_idx = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  // pixel driver: bursts of random length with random gaps
  int     burst_left = 0;
  int     gap_left = 0;
  pixel_t next_px;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) convert_pixel(blue, green, red);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          next_px = pixel_q.pop_front();
          in_valid <= 1'b1;
          blue <= next_px.b;
          green <= next_px.g;
          red <= next_px.r;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern, renewed once all its bits have been used
  logic [31:0] stall_bits = '0;
  int          stall_pos = 0;
  sample_t     want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          $error("unexpected item: plane %0d, plane_index %0d", plane, plane_index);
          error_count++;
        end else begin
          want = sample_q.pop_front();
          if (plane !== want.plane) begin
            $error("plane: expected %0d, actual %0d", want.plane, plane);
            error_count++;
          end
          if (plane_index !== want.idx) begin
            $error("plane_index: expected %0d, actual %0d", want.idx, plane_index);
            error_count++;
          end
          if (sample_value !== want.sample) begin
            $error("sample_value: expected %0d, actual %0d", want.sample, sample_value);
            error_count++;
          end
          if (last_of_run !== want.last_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_run, last_of_run);
            error_count++;
          end
          if (frame_end !== want.fend) begin
            $error("frame_end: expected %0d, actual %0d", want.fend, frame_end);
            error_count++;
          end
        end
      end
      if (stall_pos == 0) begin
        case ($urandom_range(0, 3))
          0: stall_bits = '0;
          1: stall_bits = $urandom & $urandom;
          2: stall_bits = $urandom;
          default: stall_bits = 32'h00ff_ff00;
        endcase
      end
      out_stall <= stall_bits[stall_pos];
      stall_pos = (stall_pos + 1) % 32;
    end
  end

  // register write while the converter is idle
  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  function automatic void queue_pixel(input logic [PIX_W-1:0] b, g, r);
    pixel_t p;
    p.b = b;
    p.g = g;
    p.r = r;
    pixel_q.push_back(p);
  endfunction

  // random channel value, often pinned to an extreme
  function automatic logic [PIX_W-1:0] rand_channel();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return PIX_W'($urandom);
  endfunction

  // wait until every pixel is sent and every sample has come back
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || sample_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] wv, hv;
    int random_left, frames, n;

    foreach (line_cb[i]) begin
      line_cb[i] = '0;
      line_cr[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // oversized width and height, then a shrink mid-frame with the column
    // already past the new width; row 1 reads pairs of the wider row 0
    set_size(12'd4095, 12'd4095);
    queue_pixel(8'hff, 8'h00, 8'h00);
    queue_pixel(8'hff, 8'h00, 8'h00);
    queue_pixel(8'h00, 8'hff, 8'hff);
    queue_pixel(8'h00, 8'hff, 8'hff);
    queue_pixel(8'hff, 8'hff, 8'hff);
    queue_pixel(8'h00, 8'h00, 8'h00);
    drain();
    set_size(12'd4, 12'd3);
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hff, 8'h00, 8'h00);
    queue_pixel(8'hff, 8'h00, 8'h00);
    queue_pixel(8'h00, 8'hff, 8'hff);
    queue_pixel(8'h00, 8'hff, 8'hff);
    drain();

    // sizes below the minimum: one 2x2 red block
    set_size(12'd0, 12'd1);
    repeat (4) queue_pixel(8'h00, 8'h00, 8'hff);
    drain();

    // odd width: 4x2 frame of cyan and green blocks
    set_size(12'd5, 12'd2);
    repeat (2) begin
      queue_pixel(8'hff, 8'hff, 8'h00);
      queue_pixel(8'hff, 8'hff, 8'h00);
      queue_pixel(8'h00, 8'hff, 8'h00);
      queue_pixel(8'h00, 8'hff, 8'h00);
    end
    drain();

    // random frames of random sizes, whole frames per setting
    random_left = RANDOM_PIXELS;
    while (random_left > 0) begin
      case ($urandom_range(0, 9))
        0: wv = CFG_W'($urandom_range(0, 1));
        1: wv = CFG_W'($urandom_range(14, 48));
        default: wv = CFG_W'($urandom_range(2, 12));
      endcase
      if (wv > 12) hv = 12'd2;
      else if ($urandom_range(0, 7) == 0) hv = CFG_W'($urandom_range(0, 1));
      else hv = CFG_W'($urandom_range(2, 6));
      frames = (wv > 12) ? 1 : $urandom_range(1, 2);
      if ($urandom_range(0, 1)) begin
        set_size(wv, hv);
      end else begin
        write_reg(REG_FRAME_HEIGHT, hv);
        write_reg(REG_FRAME_WIDTH, wv);
      end
      n = effective_size(wv, FRAME_MAX_W) * effective_size(hv, FRAME_MAX_H) * frames;
      repeat (n) queue_pixel(rand_channel(), rand_channel(), rand_channel());
      random_left -= n;
      drain();
    end

    // let any stray item show up before the verdict
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/rgb2i420_pkg.sv
hdl/rgb2i420_ram.sv
hdl/rgb_to_i420_converter.sv
bench/rgb_to_i420_converter_tb.sv
